// ===== hw/rtl/cmos_rtc_datetime_normalizer_unit_assert.svh =====
// Assertion macros shared by the CMOS RTC date/time normalizer RTL.
// Expects aclk and aresetn in the scope of the including module.
`ifndef CMOS_RTC_DATETIME_NORMALIZER_UNIT_ASSERT_SVH
`define CMOS_RTC_DATETIME_NORMALIZER_UNIT_ASSERT_SVH

// Plain property, checked on every clock outside reset.
`define CRDN_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Same-cycle implication: cons must hold whenever ante holds.
`define CRDN_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/crdn_pkg.sv =====
// Package for the CMOS RTC date/time normalizer: field types, constants,
// BCD decode and month-length helpers. No dependencies.
`timescale 1ns / 1ps

package crdn_pkg;

    localparam int CFG_INDEX_W = 4;
    localparam int TZ_W        = 12;
    localparam int TOTAL_W     = 15;   // holds -1440 .. 9315 minutes

    localparam logic [CFG_INDEX_W-1:0] REG_CLOCK_IS_UTC     = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TIMEZONE_MINUTES = 4'd1;

    localparam logic [7:0] HOUR_PM_MASK   = 8'h80;
    localparam int         STATUS_BINARY  = 2;    // status B bit 2
    localparam int         STATUS_24H     = 1;    // status B bit 1

    localparam logic [11:0] YEAR_BASE        = 12'd2000;
    localparam logic [6:0]  HOURS_HALF_DAY   = 7'd12;
    localparam logic signed [TZ_W-1:0] TZ_LIMIT = 12'sd1440;
    localparam logic signed [TOTAL_W-1:0] MINUTES_PER_DAY = 15'sd1440;
    localparam logic signed [TOTAL_W-1:0] TOTAL_MIN       = -15'sd1440;

    // floor(t * 1093 / 65536) == t / 60 for every t in 0 .. 1439
    localparam logic [10:0] RECIP_60 = 11'd1093;

    // Century years that are not leap years; the year never leaves 1999..2256,
    // so the divisible-by-100 and divisible-by-400 rules reduce to these two.
    localparam logic [11:0] CENTURY_2100 = 12'd2100;
    localparam logic [11:0] CENTURY_2200 = 12'd2200;

    localparam logic [7:0] MONTH_FEB = 8'd2;
    localparam logic [7:0] MONTH_DEC = 8'd12;
    localparam logic [7:0] MONTH_JAN = 8'd1;
    localparam logic [4:0] DAYS_LEAP_FEB = 5'd29;
    localparam logic [4:0] DAYS_INVALID  = 5'd30;
    localparam logic [4:0] MONTH_DAYS [0:11] = '{5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
                                                 5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};

    typedef struct packed {
        logic [7:0]  day;
        logic [7:0]  mon;
        logic [11:0] yr;
    } date_t;

    // Low nibble plus ten times the high nibble; nibbles above 9 pass through.
    function automatic logic [7:0] bcd_to_bin(input logic [7:0] v);
        logic [7:0] hi;
        hi = {4'd0, v[7:4]};
        return {4'd0, v[3:0]} + {hi[4:0], 3'd0} + {hi[6:0], 1'b0};
    endfunction

    function automatic logic [4:0] month_length(input logic [11:0] yr, input logic [7:0] mon);
        logic       leap;
        logic [4:0] len;
        leap = (yr[1:0] == 2'b00) && (yr != CENTURY_2100) && (yr != CENTURY_2200);
        if ((mon == MONTH_FEB) && leap) begin
            len = DAYS_LEAP_FEB;
        end else if ((mon >= MONTH_JAN) && (mon <= MONTH_DEC)) begin
            len = MONTH_DAYS[mon[3:0] - 4'd1];
        end else begin
            len = DAYS_INVALID;
        end
        return len;
    endfunction

endpackage

// ===== hw/rtl/cmos_rtc_datetime_normalizer_unit.sv =====
// Top level of the CMOS RTC date/time normalizer: handshakes, sequencer,
// shared minute arithmetic. Depends on crdn_pkg, crdn_date_step, assert header.
`timescale 1ns / 1ps
`include "cmos_rtc_datetime_normalizer_unit_assert.svh"

// Decodes one snapshot of the CMOS clock bytes (BCD or binary per status B
// bit 2, 12-hour PM flag in hour bit 7 unless status B bit 1 is set), adds
// 2000 to the year and, with clock_is_utc set, shifts the time by
// timezone_minutes (clamped to +/-1440) with Gregorian day/month/year
// rollover. One snapshot is worked at a time; s_ready is high only while the
// sequencer is idle. Without the shift a snapshot is decoded on the input
// transfer, then loaded into the output register. With the shift the sequencer
// forms the minute total, steps it one whole day at a time through the shared
// +/-1440 adder and calendar stepper (0 to 6 days crossed, set by the largest
// decodable hour and minute), divides it by 60 (reciprocal multiply), takes
// the remainder and loads the output. The output register waits for m_ready
// and the sequencer holds in its load step until the slot is free. The
// configuration channel is always ready; index 0 is clock_is_utc, index 1
// is timezone_minutes, other indexes are dropped. Write configuration only
// while no snapshot is in flight.
module cmos_rtc_datetime_normalizer_unit import crdn_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [TZ_W-1:0]        cfg_data,

    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [7:0]             s_raw_second,
    input  logic [7:0]             s_raw_minute,
    input  logic [7:0]             s_raw_hour,
    input  logic [7:0]             s_raw_day,
    input  logic [7:0]             s_raw_month,
    input  logic [7:0]             s_raw_year,
    input  logic [7:0]             s_mode_status,

    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [7:0]             m_second,
    output logic [5:0]             m_minute,
    output logic [4:0]             m_hour,
    output logic [7:0]             m_day,
    output logic [7:0]             m_month,
    output logic [11:0]            m_year
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_TOTAL = 3'd1;
    localparam logic [2:0] ST_STEP  = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_MOD   = 3'd4;
    localparam logic [2:0] ST_LOAD  = 3'd5;

    logic [2:0]                 state_reg, state_next;

    // configuration
    logic                       utc_reg;
    logic signed [TZ_W-1:0]     tz_reg;

    // working registers
    logic [7:0]                 sec_reg;
    logic [7:0]                 min_reg, min_next;
    logic [6:0]                 hr_reg, hr_next;
    date_t                      date_reg, date_next;
    logic signed [TOTAL_W-1:0]  total_reg, total_next;

    // output slot
    logic                       m_valid_reg;
    logic                       out_shifted_reg;
    logic [7:0]                 m_second_reg;
    logic [5:0]                 m_minute_reg;
    logic [4:0]                 m_hour_reg;
    logic [7:0]                 m_day_reg;
    logic [7:0]                 m_month_reg;
    logic [11:0]                m_year_reg;

    // input decode
    logic                       in_binary;
    logic                       in_twelve;
    logic                       in_pm;
    logic [7:0]                 hr_raw7;
    logic [7:0]                 hr_dec;
    logic [6:0]                 hr_adj;
    logic [7:0]                 day_dec;
    logic [7:0]                 mon_dec;
    logic [7:0]                 yr_dec;

    // shared arithmetic
    logic signed [TOTAL_W-1:0]  hr_times60;
    logic signed [TZ_W-1:0]     tz_sat;
    logic [21:0]                div_prod;
    logic signed [TOTAL_W-1:0]  rem_minutes;
    logic                       step_back;
    date_t                      date_stepped;
    logic                       s_xfer;
    logic                       out_free;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign s_xfer    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;

    assign m_valid  = m_valid_reg;
    assign m_second = m_second_reg;
    assign m_minute = m_minute_reg;
    assign m_hour   = m_hour_reg;
    assign m_day    = m_day_reg;
    assign m_month  = m_month_reg;
    assign m_year   = m_year_reg;

    // Decode straight from the input ports on the transfer cycle.
    assign in_binary = s_mode_status[STATUS_BINARY];
    assign in_twelve = !s_mode_status[STATUS_24H];
    assign in_pm     = (s_raw_hour & HOUR_PM_MASK) != 8'd0;
    assign hr_raw7   = s_raw_hour & ~HOUR_PM_MASK;
    assign hr_dec    = in_binary ? hr_raw7 : bcd_to_bin(hr_raw7);
    assign day_dec   = in_binary ? s_raw_day : bcd_to_bin(s_raw_day);
    assign mon_dec   = in_binary ? s_raw_month : bcd_to_bin(s_raw_month);
    assign yr_dec    = in_binary ? s_raw_year : bcd_to_bin(s_raw_year);

    always_comb begin
        hr_adj = hr_dec[6:0];
        if (in_twelve && in_pm && (hr_dec[6:0] < HOURS_HALF_DAY)) begin
            hr_adj = hr_dec[6:0] + HOURS_HALF_DAY;
        end else if (in_twelve && !in_pm && (hr_dec[6:0] == HOURS_HALF_DAY)) begin
            hr_adj = 7'd0;
        end
    end

    // Hour times 60 as (h << 6) - (h << 2); shared by the total and remainder steps.
    assign hr_times60 = $signed({2'd0, hr_reg, 6'd0} - {6'd0, hr_reg, 2'd0});

    always_comb begin
        tz_sat = tz_reg;
        if (tz_reg > TZ_LIMIT) begin
            tz_sat = TZ_LIMIT;
        end else if (tz_reg < -TZ_LIMIT) begin
            tz_sat = -TZ_LIMIT;
        end
    end

    // Divide a sub-day total by 60 with a reciprocal multiply.
    assign div_prod    = {11'd0, total_reg[10:0]} * {11'd0, RECIP_60};
    assign rem_minutes = total_reg - hr_times60;

    assign step_back = total_reg[TOTAL_W-1];

    crdn_date_step u_date_step (
        .step_back (step_back),
        .cur       (date_reg),
        .nxt       (date_stepped)
    );

    // Sequencer
    always_comb begin
        state_next = state_reg;
        min_next   = min_reg;
        hr_next    = hr_reg;
        date_next  = date_reg;
        total_next = total_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    min_next       = in_binary ? s_raw_minute : bcd_to_bin(s_raw_minute);
                    hr_next        = hr_adj;
                    date_next.day  = day_dec;
                    date_next.mon  = mon_dec;
                    date_next.yr   = {4'd0, yr_dec} + YEAR_BASE;
                    state_next     = utc_reg ? ST_TOTAL : ST_LOAD;
                end
            end
            ST_TOTAL: begin
                total_next = hr_times60 + $signed({7'd0, min_reg})
                           + {{(TOTAL_W-TZ_W){tz_sat[TZ_W-1]}}, tz_sat};
                state_next = ST_STEP;
            end
            ST_STEP: begin
                // advance or retreat one day per cycle until the total lies in one day
                if (step_back) begin
                    total_next = total_reg + MINUTES_PER_DAY;
                    date_next  = date_stepped;
                end else if (total_reg >= MINUTES_PER_DAY) begin
                    total_next = total_reg - MINUTES_PER_DAY;
                    date_next  = date_stepped;
                end else begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                hr_next    = {1'b0, div_prod[21:16]};
                state_next = ST_MOD;
            end
            ST_MOD: begin
                min_next   = rem_minutes[7:0];
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        min_reg   <= min_next;
        hr_reg    <= hr_next;
        date_reg  <= date_next;
        total_reg <= total_next;
        if (s_xfer) begin
            sec_reg <= in_binary ? s_raw_second : bcd_to_bin(s_raw_second);
        end
    end

    // Configuration registers; drop writes to unknown indexes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            utc_reg <= 1'b0;
            tz_reg  <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_CLOCK_IS_UTC:     utc_reg <= cfg_data[0];
                REG_TIMEZONE_MINUTES: tz_reg  <= $signed(cfg_data);
                default: begin
                end
            endcase
        end
    end

    // Output slot: load from the sequencer, hold until the transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg     <= 1'b0;
            out_shifted_reg <= 1'b0;
        end else if ((state_reg == ST_LOAD) && out_free) begin
            m_valid_reg     <= 1'b1;
            out_shifted_reg <= utc_reg;
        end else if (m_ready) begin
            m_valid_reg     <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == ST_LOAD) && out_free) begin
            m_second_reg <= sec_reg;
            m_minute_reg <= min_reg[5:0];
            m_hour_reg   <= hr_reg[4:0];
            m_day_reg    <= date_reg.day;
            m_month_reg  <= date_reg.mon;
            m_year_reg   <= date_reg.yr;
        end
    end

    `CRDN_ASSERT(a_busy_after_xfer, (s_valid && s_ready) |=> !s_ready, "ready after transfer")
    `CRDN_ASSERT_IMP(a_shift_in_range, m_valid && out_shifted_reg, (m_hour < 5'd24) && (m_minute < 6'd60), "shifted time out of range")
    `CRDN_ASSERT_IMP(a_step_lower_bound, state_reg == ST_STEP, total_reg >= TOTAL_MIN, "minute total below one day back")
    `CRDN_ASSERT_IMP(a_div_in_day, state_reg == ST_DIV, (total_reg >= 0) && (total_reg < MINUTES_PER_DAY), "total not within one day")

endmodule

// ===== hw/rtl/crdn_date_step.sv =====
// One-day calendar step (forward or back) with month/year rollover.
// Depends on crdn_pkg for date_t and month_length.
`timescale 1ns / 1ps

module crdn_date_step import crdn_pkg::*; (
    input  logic  step_back,
    input  date_t cur,
    output date_t nxt
);

    logic [7:0]  day_inc;
    logic [7:0]  day_dec;
    logic [7:0]  mon_inc;
    logic [7:0]  mon_dec;
    logic [11:0] yr_prev;

    assign day_inc = cur.day + 8'd1;
    assign day_dec = cur.day - 8'd1;
    assign mon_inc = cur.mon + 8'd1;
    assign mon_dec = cur.mon - 8'd1;
    assign yr_prev = cur.yr - 12'd1;

    always_comb begin
        nxt = cur;
        if (step_back) begin
            nxt.day = day_dec;
            if (day_dec == 8'd0) begin
                // borrow a month; month zero wraps into December of last year
                if (mon_dec == 8'd0) begin
                    nxt.mon = MONTH_DEC;
                    nxt.yr  = yr_prev;
                    nxt.day = {3'd0, month_length(yr_prev, MONTH_DEC)};
                end else begin
                    nxt.mon = mon_dec;
                    nxt.day = {3'd0, month_length(cur.yr, mon_dec)};
                end
            end
        end else begin
            nxt.day = day_inc;
            if (day_inc > {3'd0, month_length(cur.yr, cur.mon)}) begin
                nxt.day = 8'd1;
                nxt.mon = mon_inc;
                if (mon_inc > MONTH_DEC) begin
                    nxt.mon = MONTH_JAN;
                    nxt.yr  = cur.yr + 12'd1;
                end
            end
        end
    end

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for cmos_rtc_datetime_normalizer_unit: directed table, then random
// snapshots under several idle/stall mixes, each checked against an in-bench predictor.
// Depends on crdn_pkg and the RTL top level only.
`timescale 1ns / 1ps

module tb_top;
    import crdn_pkg::*;

    // Status B mode bytes: bit 2 selects binary, bit 1 selects 24-hour form.
    localparam logic [7:0] MODE_BCD_12H = 8'h00;
    localparam logic [7:0] MODE_BCD_24H = 8'h02;
    localparam logic [7:0] MODE_BIN_12H = 8'h04;
    localparam logic [7:0] MODE_BIN_24H = 8'h06;

    // Timezone register values, two's complement in 12 bits.
    localparam logic [TZ_W-1:0] TZ_ZERO       = 12'h000;
    localparam logic [TZ_W-1:0] TZ_PLUS_MIN   = 12'h001;
    localparam logic [TZ_W-1:0] TZ_MINUS_MIN  = 12'hFFF;
    localparam logic [TZ_W-1:0] TZ_PLUS_HOUR  = 12'h03C;
    localparam logic [TZ_W-1:0] TZ_MINUS_HOUR = 12'hFC4;
    localparam logic [TZ_W-1:0] TZ_PLUS_DAY   = 12'h5A0;
    localparam logic [TZ_W-1:0] TZ_MINUS_DAY  = 12'hA60;
    localparam logic [TZ_W-1:0] TZ_MAX        = 12'h7FF;
    localparam logic [TZ_W-1:0] TZ_MIN        = 12'h800;

    localparam logic [CFG_INDEX_W-1:0] REG_FIRST_UNUSED = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_LAST_UNUSED  = 4'd15;

    localparam int TZ_CLAMP        = 1440;
    localparam int DAY_MINUTES     = 24 * 60;
    localparam int DRAIN_CYCLES    = 24;
    localparam int PRESSURE_HOLD   = 300;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int PHASES          = 4;
    localparam int SETTINGS_PER_PH = 8;
    localparam int ITEMS_PER_SET   = 48;

    typedef struct packed {
        logic [7:0] second;
        logic [7:0] minute;
        logic [7:0] hour;
        logic [7:0] day;
        logic [7:0] month;
        logic [7:0] year;
        logic [7:0] status;
    } snapshot_t;

    typedef struct packed {
        logic [7:0]  second;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [7:0]  day;
        logic [7:0]  month;
        logic [11:0] year;
    } datetime_t;

    typedef struct packed {
        bit              utc;
        logic [TZ_W-1:0] tz;
        snapshot_t       stim;
        bit              typed;
        datetime_t       want;
    } vector_t;

    localparam datetime_t NO_RESULT = '0;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [TZ_W-1:0]        cfg_data;
    logic                   s_valid;
    logic                   s_ready;
    logic [7:0]             s_raw_second;
    logic [7:0]             s_raw_minute;
    logic [7:0]             s_raw_hour;
    logic [7:0]             s_raw_day;
    logic [7:0]             s_raw_month;
    logic [7:0]             s_raw_year;
    logic [7:0]             s_mode_status;
    logic                   m_valid;
    logic                   m_ready;
    logic [7:0]             m_second;
    logic [5:0]             m_minute;
    logic [4:0]             m_hour;
    logic [7:0]             m_day;
    logic [7:0]             m_month;
    logic [11:0]            m_year;

    // Shadow of the configuration registers, updated on each config transfer.
    bit                     shadow_utc = 1'b0;
    logic signed [TZ_W-1:0] shadow_tz  = '0;

    datetime_t datetimes_due[$];
    bit        typed_armed;     // next input transfer carries a hand-written result
    datetime_t typed_result;
    int        error_count = 0;
    int        cycle_count = 0;
    int        send_idle_pct;
    int        stall_pct;
    int        hold_request = 0; // bumped by main to ask for a receiver hold-off
    int        hold_served  = 0;
    int        hold_off     = 0;

    // Directed snapshots: the first block runs with the reset configuration.
    // Results are written out only where they are obvious; other rows use the predictor.
    vector_t directed_vectors [0:24] = '{
        // BCD upper corner, 24-hour
        '{1'b0, TZ_ZERO, '{8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99, MODE_BCD_24H},
          1'b1, '{8'd59, 6'd59, 5'd23, 8'd31, 8'd12, 12'd2099}},
        // all-zero registers
        '{1'b0, TZ_ZERO, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, MODE_BCD_24H},
          1'b1, '{8'd0, 6'd0, 5'd0, 8'd0, 8'd0, 12'd2000}},
        // binary all-ones: hour and minute come back in their low bits only
        '{1'b0, TZ_ZERO, '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
          1'b1, '{8'd255, 6'd63, 5'd31, 8'd255, 8'd255, 12'd2255}},
        // BCD with nibbles above nine, 12-hour PM, stray status bits
        '{1'b0, TZ_ZERO, '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hF9},
          1'b0, NO_RESULT},
        // 12 AM maps to hour zero
        '{1'b0, TZ_ZERO, '{8'h00, 8'h15, 8'h12, 8'h01, 8'h01, 8'h00, MODE_BCD_12H},
          1'b1, '{8'd0, 6'd15, 5'd0, 8'd1, 8'd1, 12'd2000}},
        // 1 PM
        '{1'b0, TZ_ZERO, '{8'h30, 8'h45, 8'h81, 8'h15, 8'h06, 8'h07, MODE_BCD_12H},
          1'b0, NO_RESULT},
        // 12 PM stays at twelve
        '{1'b0, TZ_ZERO, '{8'h30, 8'h45, 8'h92, 8'h15, 8'h06, 8'h07, MODE_BCD_12H},
          1'b0, NO_RESULT},
        // binary 11 PM
        '{1'b0, TZ_ZERO, '{8'd30, 8'd45, 8'h8B, 8'd15, 8'd6, 8'd7, MODE_BIN_12H},
          1'b0, NO_RESULT},
        // hour bit 7 dropped in 24-hour form
        '{1'b0, TZ_ZERO, '{8'd30, 8'd45, 8'h80, 8'd15, 8'd6, 8'd7, MODE_BIN_24H},
          1'b0, NO_RESULT},
        // New Year forward across the year end
        '{1'b1, TZ_PLUS_HOUR, '{8'h45, 8'h30, 8'h23, 8'h31, 8'h12, 8'h23, MODE_BCD_24H},
          1'b0, NO_RESULT},
        // back into February 29 of a leap year
        '{1'b1, TZ_MINUS_HOUR, '{8'h10, 8'h10, 8'h00, 8'h01, 8'h03, 8'h24, MODE_BCD_24H},
          1'b0, NO_RESULT},
        // century year 2100 is not leap
        '{1'b1, TZ_MINUS_HOUR, '{8'd10, 8'd10, 8'd0, 8'd1, 8'd3, 8'd100, MODE_BIN_24H},
          1'b0, NO_RESULT},
        // year 2000 is leap by the 400 rule
        '{1'b1, TZ_MINUS_HOUR, '{8'd0, 8'd10, 8'd0, 8'd1, 8'd3, 8'd0, MODE_BIN_24H},
          1'b0, NO_RESULT},
        // day zero stepping back wraps to 255, no rollover
        '{1'b1, TZ_MINUS_HOUR, '{8'd0, 8'd0, 8'd0, 8'd0, 8'd5, 8'd30, MODE_BIN_24H},
          1'b0, NO_RESULT},
        // month zero stepping back wraps to 255, which counts as 30 days
        '{1'b1, TZ_MINUS_HOUR, '{8'd0, 8'd0, 8'd0, 8'd1, 8'd0, 8'd30, MODE_BIN_24H},
          1'b0, NO_RESULT},
        // January 1 back into December of the year before
        '{1'b1, TZ_MINUS_HOUR, '{8'd0, 8'd0, 8'd0, 8'd1, 8'd1, 8'd50, MODE_BIN_24H},
          1'b0, NO_RESULT},
        // most negative register value saturates to one day back, below 2000
        '{1'b1, TZ_MIN, '{8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00, MODE_BCD_24H},
          1'b1, '{8'd0, 6'd0, 5'd0, 8'd31, 8'd12, 12'd1999}},
        // exactly one day back
        '{1'b1, TZ_MINUS_DAY, '{8'd0, 8'd0, 8'd0, 8'd1, 8'd3, 8'd0, MODE_BIN_24H},
          1'b0, NO_RESULT},
        // largest hour and minute with saturated positive offset: six days ahead
        '{1'b1, TZ_MAX, '{8'd0, 8'd255, 8'd127, 8'd28, 8'd2, 8'd24, MODE_BIN_24H},
          1'b0, NO_RESULT},
        // exactly one day ahead into the top year
        '{1'b1, TZ_PLUS_DAY, '{8'd0, 8'd0, 8'd12, 8'd31, 8'd12, 8'd255, MODE_BIN_24H},
          1'b0, NO_RESULT},
        // day 255 stepping forward wraps to zero, no rollover
        '{1'b1, TZ_PLUS_HOUR, '{8'd0, 8'd30, 8'd23, 8'd255, 8'd5, 8'd30, MODE_BIN_24H},
          1'b0, NO_RESULT},
        // month 13 counts as 30 days and rolls into next January
        '{1'b1, TZ_PLUS_HOUR, '{8'd0, 8'd30, 8'd23, 8'd30, 8'd13, 8'd30, MODE_BIN_24H},
          1'b0, NO_RESULT},
        // month 255 stepping forward wraps to zero
        '{1'b1, TZ_PLUS_HOUR, '{8'd0, 8'd30, 8'd23, 8'd30, 8'd255, 8'd30, MODE_BIN_24H},
          1'b0, NO_RESULT},
        // out-of-range hour with zero offset still gets folded into days
        '{1'b1, TZ_ZERO, '{8'd0, 8'd0, 8'd100, 8'd10, 8'd4, 8'd30, MODE_BIN_24H},
          1'b0, NO_RESULT},
        // 12 AM minus one minute
        '{1'b1, TZ_MINUS_MIN, '{8'h00, 8'h00, 8'h12, 8'h01, 8'h01, 8'h00, MODE_BCD_12H},
          1'b0, NO_RESULT}
    };

    cmos_rtc_datetime_normalizer_unit u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_raw_second  (s_raw_second),
        .s_raw_minute  (s_raw_minute),
        .s_raw_hour    (s_raw_hour),
        .s_raw_day     (s_raw_day),
        .s_raw_month   (s_raw_month),
        .s_raw_year    (s_raw_year),
        .s_mode_status (s_mode_status),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_second      (m_second),
        .m_minute      (m_minute),
        .m_hour        (m_hour),
        .m_day         (m_day),
        .m_month       (m_month),
        .m_year        (m_year)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ---------------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------------

    // Nibbles above nine are not rejected; they simply weigh in.
    function automatic int bcd_value(input logic [7:0] v);
        return int'(v[3:0]) + int'(v[7:4]) * 10;
    endfunction

    // Gregorian month length; anything outside 1..12 counts as 30 days.
    function automatic int month_span(input int yr, input int mon);
        bit leap;
        leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
        case (mon)
            2: return leap ? 29 : 28;
            4, 6, 9, 11: return 30;
            1, 3, 5, 7, 8, 10, 12: return 31;
            default: return 30;
        endcase
    endfunction

    function automatic datetime_t predict_datetime(input snapshot_t snap, input bit utc,
                                                   input logic signed [TZ_W-1:0] offset);
        int        sec;
        int        mn;
        int        hr;
        int        day;
        int        mon;
        int        yr;
        int        tz;
        int        total;
        bit        binary;
        bit        twelve;
        bit        pm;
        datetime_t r;
        binary = snap.status[2];
        twelve = !snap.status[1];
        pm     = snap.hour[7];
        sec    = snap.second;
        mn     = snap.minute;
        hr     = snap.hour[6:0];
        day    = snap.day;
        mon    = snap.month;
        yr     = snap.year;
        if (!binary) begin
            sec = bcd_value(snap.second);
            mn  = bcd_value(snap.minute);
            hr  = bcd_value({1'b0, snap.hour[6:0]});
            day = bcd_value(snap.day);
            mon = bcd_value(snap.month);
            yr  = bcd_value(snap.year);
        end
        if (twelve && pm && hr < 12) begin
            hr = hr + 12;
        end
        if (twelve && !pm && hr == 12) begin
            hr = 0;
        end
        yr = yr + 2000;

        if (utc) begin
            tz = offset;
            if (tz > TZ_CLAMP) begin
                tz = TZ_CLAMP;
            end
            if (tz < -TZ_CLAMP) begin
                tz = -TZ_CLAMP;
            end
            total = hr * 60 + mn + tz;
            // Step back one day at a time; day and month wrap modulo 256.
            while (total < 0) begin
                total = total + DAY_MINUTES;
                day   = (day - 1) & 255;
                if (day == 0) begin
                    mon = (mon - 1) & 255;
                    if (mon == 0) begin
                        mon = 12;
                        yr  = yr - 1;
                    end
                    day = month_span(yr, mon);
                end
            end
            while (total >= DAY_MINUTES) begin
                total = total - DAY_MINUTES;
                day   = (day + 1) & 255;
                if (day > month_span(yr, mon)) begin
                    day = 1;
                    mon = (mon + 1) & 255;
                    if (mon > 12) begin
                        mon = 1;
                        yr  = yr + 1;
                    end
                end
            end
            hr = total / 60;
            mn = total % 60;
        end

        r.second = sec[7:0];
        r.minute = mn[5:0];
        r.hour   = hr[4:0];
        r.day    = day[7:0];
        r.month  = mon[7:0];
        r.year   = yr[11:0];
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // Random stimulus
    // ---------------------------------------------------------------------

    function automatic logic [7:0] encode_field(input int v, input bit binary);
        return binary ? v[7:0] : 8'(((v / 10) << 4) | (v % 10));
    endfunction

    // Mostly well-formed snapshots that sit near day, month and year edges,
    // with a quarter of pure noise bytes.
    function automatic snapshot_t random_snapshot();
        snapshot_t   s;
        logic [63:0] noise;
        bit          binary;
        bit          h24;
        int          yr;
        int          mon;
        int          day;
        int          len;
        int          hr;
        int          h12;
        int          mn;
        if ($urandom_range(0, 3) == 0) begin
            noise = {$urandom(), $urandom()};
            s     = noise[55:0];
            return s;
        end
        binary = $urandom_range(0, 1);
        h24    = $urandom_range(0, 1);
        yr     = binary ? $urandom_range(0, 255) : $urandom_range(0, 99);
        mon    = $urandom_range(1, 12);
        len    = month_span(2000 + yr, mon);
        case ($urandom_range(0, 3))
            0: day = 1;
            1: day = len;
            2: day = len - 1;
            default: day = $urandom_range(1, len);
        endcase
        if ($urandom_range(0, 2) == 0) begin
            hr = $urandom_range(0, 1) ? 23 : 0;
        end else begin
            hr = $urandom_range(0, 23);
        end
        if ($urandom_range(0, 1) == 0) begin
            mn = $urandom_range(0, 1) ? 59 : 0;
        end else begin
            mn = $urandom_range(0, 59);
        end

        s.second = encode_field($urandom_range(0, 59), binary);
        s.minute = encode_field(mn, binary);
        if (h24) begin
            s.hour = encode_field(hr, binary);
        end else begin
            h12    = (hr % 12 == 0) ? 12 : hr % 12;
            s.hour = encode_field(h12, binary) | ((hr >= 12) ? HOUR_PM_MASK : 8'h00);
        end
        s.day    = encode_field(day, binary);
        s.month  = encode_field(mon, binary);
        s.year   = encode_field(yr, binary);
        s.status = 8'($urandom_range(0, 255));
        s.status[STATUS_BINARY] = binary;
        s.status[STATUS_24H]    = h24;
        return s;
    endfunction

    function automatic logic [TZ_W-1:0] random_offset();
        case ($urandom_range(0, 3))
            0: begin
                case ($urandom_range(0, 8))
                    0: return TZ_MIN;
                    1: return TZ_MINUS_DAY;
                    2: return TZ_MINUS_MIN;
                    3: return TZ_ZERO;
                    4: return TZ_PLUS_MIN;
                    5: return TZ_PLUS_DAY;
                    6: return TZ_MAX;
                    7: return TZ_PLUS_HOUR;
                    default: return TZ_MINUS_HOUR;
                endcase
            end
            1: return 12'($urandom_range(0, 4095));
            default: return 12'(int'($urandom_range(0, 2 * TZ_CLAMP)) - TZ_CLAMP);
        endcase
    endfunction

    // ---------------------------------------------------------------------
    // Drivers: every task starts and ends just after a falling edge, with no
    // assignment yet made in that time step.
    // ---------------------------------------------------------------------

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [TZ_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // Write both registers, then poke an unused index that must be dropped.
    task automatic apply_config(input bit utc, input logic [TZ_W-1:0] tz);
        write_reg(REG_CLOCK_IS_UTC, {11'($urandom_range(0, 2047)), utc});
        write_reg(REG_TIMEZONE_MINUTES, tz);
        write_reg(4'($urandom_range(REG_FIRST_UNUSED, REG_LAST_UNUSED)),
                  12'($urandom_range(0, 4095)));
    endtask

    // Offer one snapshot; hold valid and payload until the transfer.
    task automatic push_snapshot(input snapshot_t snap, input bit typed, input datetime_t want);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        typed_armed   = typed;
        typed_result  = want;
        s_valid       <= 1'b1;
        s_raw_second  <= snap.second;
        s_raw_minute  <= snap.minute;
        s_raw_hour    <= snap.hour;
        s_raw_day     <= snap.day;
        s_raw_month   <= snap.month;
        s_raw_year    <= snap.year;
        s_mode_status <= snap.status;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Drop valid, wait for every outstanding result, then let the pipe empty.
    task automatic settle();
        s_valid <= 1'b0;
        while (datetimes_due.size() != 0) begin
            @(negedge aclk);
        end
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // Receiver: random stalls, plus a counted hold-off that main can request.
    always @(negedge aclk) begin
        if (hold_request != hold_served) begin
            hold_served = hold_request;
            hold_off    = PRESSURE_HOLD;
        end
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off = hold_off - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // ---------------------------------------------------------------------
    // Monitor and scoreboard: everything sampled at the rising edge.
    // ---------------------------------------------------------------------

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge aclk) begin : scoreboard
        snapshot_t seen;
        datetime_t want;
        if (aresetn) begin
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("%0t: timeout after %0d cycles", $time, cycle_count);
                $display("** cmos_rtc_datetime_normalizer_unit: FAILED **");
                $finish;
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_CLOCK_IS_UTC:     shadow_utc = cfg_data[0];
                    REG_TIMEZONE_MINUTES: shadow_tz  = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                if (typed_armed) begin
                    datetimes_due.push_back(typed_result);
                end else begin
                    seen = {s_raw_second, s_raw_minute, s_raw_hour, s_raw_day,
                            s_raw_month, s_raw_year, s_mode_status};
                    datetimes_due.push_back(predict_datetime(seen, shadow_utc, shadow_tz));
                end
            end
            if (m_valid && m_ready) begin
                if (datetimes_due.size() == 0) begin
                    $display("%0t: unexpected result transfer, nothing expected", $time);
                    error_count++;
                end else begin
                    want = datetimes_due.pop_front();
                    check_field("second", want.second, m_second);
                    check_field("minute", want.minute, m_minute);
                    check_field("hour",   want.hour,   m_hour);
                    check_field("day",    want.day,    m_day);
                    check_field("month",  want.month,  m_month);
                    check_field("year",   want.year,   m_year);
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------

    initial begin : main_seq
        bit              cur_utc;
        logic [TZ_W-1:0] cur_tz;
        aresetn       = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        s_valid       = 1'b0;
        s_raw_second  = '0;
        s_raw_minute  = '0;
        s_raw_hour    = '0;
        s_raw_day     = '0;
        s_raw_month   = '0;
        s_raw_year    = '0;
        s_mode_status = '0;
        typed_armed   = 1'b0;
        typed_result  = NO_RESULT;
        send_idle_pct = 0;
        stall_pct     = 0;

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed table; reconfigure only when a row asks for a new setting.
        cur_utc = 1'b0;
        cur_tz  = TZ_ZERO;
        foreach (directed_vectors[i]) begin
            if (directed_vectors[i].utc != cur_utc || directed_vectors[i].tz != cur_tz) begin
                settle();
                cur_utc = directed_vectors[i].utc;
                cur_tz  = directed_vectors[i].tz;
                apply_config(cur_utc, cur_tz);
            end
            push_snapshot(directed_vectors[i].stim, directed_vectors[i].typed,
                          directed_vectors[i].want);
        end

        // Random part: four idle mixes, each walking several configurations.
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 66; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 66; end
                default: begin send_idle_pct = 27; stall_pct = 27; end
            endcase
            for (int set = 0; set < SETTINGS_PER_PH; set++) begin
                settle();
                apply_config($urandom_range(0, 3) != 0, random_offset());
                // Back-pressure: hold the receiver off while the sender keeps
                // offering, so the output slot fills and input stalls.
                if (ph == 0 && set == 1) begin
                    hold_request = hold_request + 1;
                end
                for (int n = 0; n < ITEMS_PER_SET; n++) begin
                    push_snapshot(random_snapshot(), 1'b0, NO_RESULT);
                end
            end
        end

        settle();
        if (error_count == 0) begin
            $display("** cmos_rtc_datetime_normalizer_unit: PASSED **");
        end else begin
            $display("** cmos_rtc_datetime_normalizer_unit: FAILED **");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/crdn_pkg.sv
hw/rtl/crdn_date_step.sv
hw/rtl/cmos_rtc_datetime_normalizer_unit.sv
test/tb_top.sv
